@@ sv/dds_pkg.sv @@
// shared constants, codes and wave table functions of the dds waveform generator
package dds_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int SAMPLE_BITS     = 8;
  localparam int FREQ_BITS       = 32;
  localparam int WAVE_BITS       = 2;
  localparam int POINT_BITS      = 8;

  localparam int DOWN_SHIFT = (TABLE_ADDR_BITS >= POINT_BITS) ? (TABLE_ADDR_BITS - POINT_BITS) : 0;
  localparam int UP_SHIFT   = (TABLE_ADDR_BITS < POINT_BITS) ? (POINT_BITS - TABLE_ADDR_BITS) : 0;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [TABLE_ADDR_BITS-1:0] taddr_t;
  typedef logic [POINT_BITS-1:0]      point_t;
  typedef logic [SAMPLE_BITS-1:0]     sample_t;
  typedef logic [WAVE_BITS-1:0]       wave_t;
  typedef logic [FREQ_BITS-1:0]       freq_t;
  typedef logic [CFG_INDEX_BITS-1:0]  cfg_index_t;
  typedef logic [FIFO_CNT_BITS-1:0]   fifo_cnt_t;

  // register indexes
  localparam cfg_index_t REG_FREQUENCY_WORD = CFG_INDEX_BITS'(0);
  localparam cfg_index_t REG_WAVEFORM       = CFG_INDEX_BITS'(1);

  // waveform codes
  localparam wave_t WAVE_SQUARE   = 2'd0;
  localparam wave_t WAVE_SINE     = 2'd1;
  localparam wave_t WAVE_TRIANGLE = 2'd2;
  localparam wave_t WAVE_RAMP     = 2'd3;

  localparam freq_t  FREQ_RESET = FREQ_BITS'(1050000);
  localparam wave_t  WAVE_RESET = WAVE_SINE;

  // map a table address onto the 8-bit point index
  function automatic point_t point_index(input taddr_t addr);
    logic [TABLE_ADDR_BITS+POINT_BITS-1:0] w;
    begin
      w = ((TABLE_ADDR_BITS+POINT_BITS)'(addr) >> DOWN_SHIFT) << UP_SHIFT;
      return w[POINT_BITS-1:0];
    end
  endfunction

  // floor(127*sin(pi*k/128)) for k = 0..64
  function automatic logic [6:0] quarter_sine(input logic [6:0] k);
    logic [6:0] v;
    begin
      unique case (k)
        7'd0:  v = 7'd0;   7'd1:  v = 7'd3;   7'd2:  v = 7'd6;   7'd3:  v = 7'd9;
        7'd4:  v = 7'd12;  7'd5:  v = 7'd15;  7'd6:  v = 7'd18;  7'd7:  v = 7'd21;
        7'd8:  v = 7'd24;  7'd9:  v = 7'd27;  7'd10: v = 7'd30;  7'd11: v = 7'd33;
        7'd12: v = 7'd36;  7'd13: v = 7'd39;  7'd14: v = 7'd42;  7'd15: v = 7'd45;
        7'd16: v = 7'd48;  7'd17: v = 7'd51;  7'd18: v = 7'd54;  7'd19: v = 7'd57;
        7'd20: v = 7'd59;  7'd21: v = 7'd62;  7'd22: v = 7'd65;  7'd23: v = 7'd67;
        7'd24: v = 7'd70;  7'd25: v = 7'd73;  7'd26: v = 7'd75;  7'd27: v = 7'd78;
        7'd28: v = 7'd80;  7'd29: v = 7'd82;  7'd30: v = 7'd85;  7'd31: v = 7'd87;
        7'd32: v = 7'd89;  7'd33: v = 7'd91;  7'd34: v = 7'd94;  7'd35: v = 7'd96;
        7'd36: v = 7'd98;  7'd37: v = 7'd100; 7'd38: v = 7'd102; 7'd39: v = 7'd103;
        7'd40: v = 7'd105; 7'd41: v = 7'd107; 7'd42: v = 7'd108; 7'd43: v = 7'd110;
        7'd44: v = 7'd112; 7'd45: v = 7'd113; 7'd46: v = 7'd114; 7'd47: v = 7'd116;
        7'd48: v = 7'd117; 7'd49: v = 7'd118; 7'd50: v = 7'd119; 7'd51: v = 7'd120;
        7'd52: v = 7'd121; 7'd53: v = 7'd122; 7'd54: v = 7'd123; 7'd55: v = 7'd123;
        7'd56: v = 7'd124; 7'd57: v = 7'd125; 7'd58: v = 7'd125; 7'd59: v = 7'd126;
        7'd60: v = 7'd126; 7'd61: v = 7'd126; 7'd62: v = 7'd126; 7'd63: v = 7'd126;
        7'd64: v = 7'd127;
        default: v = 7'd0;
      endcase
      return v;
    end
  endfunction

  // sine point from the quarter-wave table, floor of 127*sin + 127
  function automatic sample_t sine_point(input point_t j);
    point_t k;
    begin
      if (j <= 8'd64) begin
        return 8'd127 + {1'b0, quarter_sine(j[6:0])};
      end else if (j <= 8'd128) begin
        return 8'd127 + {1'b0, quarter_sine(7'(8'd128 - j))};
      end else begin
        k = (j <= 8'd192) ? (j - 8'd128) : (8'd0 - j);
        if (k == 8'd64) begin
          return 8'd0;
        end else begin
          return 8'd126 - {1'b0, quarter_sine(k[6:0])};
        end
      end
    end
  endfunction

  function automatic sample_t wave_point(input wave_t wave, input point_t j);
    logic [8:0] tri_down;
    begin
      tri_down = 9'd511 - {j, 1'b0};
      unique case (wave)
        WAVE_SQUARE:   return j[7] ? 8'd255 : 8'd0;
        WAVE_SINE:     return sine_point(j);
        WAVE_TRIANGLE: return j[7] ? tri_down[7:0] : {j[6:0], 1'b0};
        WAVE_RAMP:     return j;
        default:       return j;
      endcase
    end
  endfunction

endpackage

@@ sv/dds_wave_rom.sv @@
// synchronous wave table rom, one read per cycle, registered data
module dds_wave_rom (
  input  logic              clk,
  input  logic              rd_en,
  input  dds_pkg::wave_t    rd_wave,
  input  dds_pkg::taddr_t   rd_addr,
  output dds_pkg::sample_t  rd_data
);

  dds_pkg::sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= dds_pkg::wave_point(rd_wave, dds_pkg::point_index(rd_addr));
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/dds_out_fifo.sv @@
// small result fifo that decouples the rom read from the output stall
module dds_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dds_pkg::sample_t    push_data,
  output logic                pop_valid,
  input  logic                pop_stall,
  output dds_pkg::sample_t    pop_data,
  output dds_pkg::fifo_cnt_t  count
);

  dds_pkg::sample_t mem_r [dds_pkg::FIFO_DEPTH];
  logic [dds_pkg::FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dds_pkg::FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  dds_pkg::fifo_cnt_t cnt_r, cnt_nxt;
  logic pop;

  assign pop = pop_valid & ~pop_stall;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + dds_pkg::FIFO_CNT_BITS'(push) - dds_pkg::FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

@@ sv/dds_waveform_generator.sv @@
// top level of the dds waveform generator: phase accumulator, wave rom and result fifo
//
// direct digital synthesizer. every accepted item with in_advance set adds the
// frequency word to a 32-bit phase accumulator that wraps; with in_advance clear
// the phase holds. the top 8 bits of the new phase, together with the waveform
// register, address a synchronous wave table rom (square, sine, triangle, ramp)
// and the entry read comes out as out_sample, one result per item, in order.
// throughput is one item per cycle while in_stall is low: the accumulator add and
// the rom read are registered at the accepting edge, then the rom output register
// writes the result into the fifo and out_valid rises. results pass through a
// four-entry fifo; in_stall rises only when that fifo and the rom output together
// hold four results, so a stalled output side stops the input after the fifo fills.
// configuration: index 0 is the frequency word (32 bits, reset 1050000), index 1
// the waveform (2 bits: 0 square, 1 sine, 2 triangle, 3 ramp; reset sine).
// writes to other indexes are ignored; cfg_ready is always high. registers are
// meant to be written while no items are in flight.
module dds_waveform_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_advance,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_sample,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  dds_pkg::cfg_index_t        cfg_index,
  input  logic [dds_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  dds_pkg::freq_t  freq_r;
  dds_pkg::wave_t  wave_r;

  // accumulator state
  dds_pkg::phase_t phase_r, phase_nxt;

  // rom read in flight
  logic              rd_valid_r;
  dds_pkg::sample_t  rd_data;
  dds_pkg::fifo_cnt_t fifo_cnt;
  logic [dds_pkg::FIFO_CNT_BITS:0] in_flight;
  logic              accept;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= dds_pkg::FREQ_RESET;
      wave_r <= dds_pkg::WAVE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dds_pkg::REG_FREQUENCY_WORD) begin
        freq_r <= cfg_data[dds_pkg::FREQ_BITS-1:0];
      end else if (cfg_index == dds_pkg::REG_WAVEFORM) begin
        wave_r <= cfg_data[dds_pkg::WAVE_BITS-1:0];
      end
    end
  end

  // results already committed: any in the rom register plus those in the fifo
  assign in_flight = (dds_pkg::FIFO_CNT_BITS+1)'(fifo_cnt)
                   + (dds_pkg::FIFO_CNT_BITS+1)'(rd_valid_r);
  assign in_stall  = (in_flight >= (dds_pkg::FIFO_CNT_BITS+1)'(dds_pkg::FIFO_DEPTH));
  assign accept    = in_valid & ~in_stall;

  // accumulate, wrapping at the phase width
  always_comb begin
    phase_nxt = phase_r;
    if (accept && in_advance) begin
      phase_nxt = phase_r + dds_pkg::PHASE_BITS'(freq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      rd_valid_r <= accept;
    end
  end

  // table lookup on the top bits of the new phase
  dds_wave_rom u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_wave (wave_r),
    .rd_addr (phase_nxt[dds_pkg::PHASE_BITS-1 -: dds_pkg::TABLE_ADDR_BITS]),
    .rd_data (rd_data)
  );

  dds_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_valid_r),
    .push_data (rd_data),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (out_sample),
    .count     (fifo_cnt)
  );

`ifndef ASSERT_OFF
  // the phase moves only on an accepted item
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(phase_r))
    else $error("phase changed without an accepted item");

  // committed results never exceed the fifo depth
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= (dds_pkg::FIFO_CNT_BITS+1)'(dds_pkg::FIFO_DEPTH))
    else $error("result fifo overrun");

  // a rom read is pending in the cycle after an accepted item
  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> rd_valid_r)
    else $error("rom read lost");

  // an accepted advance without a register write steps the phase by the frequency word
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_advance && !cfg_we |=>
      (phase_r == $past(phase_r) + dds_pkg::PHASE_BITS'($past(freq_r))))
    else $error("phase step wrong");
`endif

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the dds waveform generator: directed and random items
`timescale 1ns / 1ps

module testbench;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  // rom read plus fifo: settle time after the last pending sample
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 60;
  localparam int SEGMENT_ITEMS = 48;
  localparam dds_pkg::cfg_index_t REG_UNMAPPED   = dds_pkg::CFG_INDEX_BITS'(2);
  localparam dds_pkg::cfg_index_t REG_LAST_INDEX = '1;

  // every input known from time zero
  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_valid   = 1'b0;
  logic                              in_advance = 1'b0;
  logic                              out_stall  = 1'b0;
  logic                              cfg_valid  = 1'b0;
  dds_pkg::cfg_index_t               cfg_index  = '0;
  logic [dds_pkg::CFG_DATA_BITS-1:0] cfg_data   = '0;
  logic                              in_stall;
  logic                              out_valid;
  logic [7:0]                        out_sample;
  logic                              cfg_ready;

  always #HALF_PERIOD clk = ~clk;

  dds_waveform_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_advance (in_advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor copy of the accumulator and the registers
  dds_pkg::phase_t  acc_phase = '0;
  dds_pkg::freq_t   freq_word = dds_pkg::FREQ_RESET;
  dds_pkg::wave_t   wave_sel  = dds_pkg::WAVE_RESET;

  // samples predicted for accepted items, oldest first
  dds_pkg::sample_t pending_samples[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  // floor(127*sin(pi*k/128)) for k = 0..64
  logic [6:0] sine_quarter [0:64] = '{
    0, 3, 6, 9, 12, 15, 18, 21, 24, 27, 30, 33, 36, 39, 42, 45,
    48, 51, 54, 57, 59, 62, 65, 67, 70, 73, 75, 78, 80, 82, 85, 87,
    89, 91, 94, 96, 98, 100, 102, 103, 105, 107, 108, 110, 112, 113, 114, 116,
    117, 118, 119, 120, 121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126,
    127
  };

  // sine from the quarter wave: first half rises above midscale, second half below
  function automatic dds_pkg::sample_t sine_value(input dds_pkg::point_t j);
    dds_pkg::point_t k;
    if (j <= 8'd64) return 8'd127 + sine_quarter[j];
    if (j <= 8'd128) return 8'd127 + sine_quarter[8'd128 - j];
    // lower half: floor(127 - s) is one below 127 - floor(s) unless s is whole
    k = (j <= 8'd192) ? (j - 8'd128) : (8'd0 - j);
    if (k == 8'd64) return 8'd0;
    return 8'd126 - sine_quarter[k];
  endfunction

  // sample for a phase under a waveform; the top phase bits are the point index
  function automatic dds_pkg::sample_t dds_sample(input dds_pkg::wave_t w,
                                                  input dds_pkg::phase_t ph);
    dds_pkg::point_t j;
    logic [8:0]      tri_val;
    j = ph[dds_pkg::PHASE_BITS-1 -: dds_pkg::POINT_BITS];
    tri_val = j[7] ? (9'd511 - {j, 1'b0}) : {j, 1'b0};
    case (w)
      dds_pkg::WAVE_SQUARE:   return j[7] ? 8'd255 : 8'd0;
      dds_pkg::WAVE_SINE:     return sine_value(j);
      dds_pkg::WAVE_TRIANGLE: return tri_val[7:0];
      default:                return j;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // outputs settle by the falling edge; a result seen here is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with nothing pending", out_sample, -1);
      end else begin
        if (out_sample !== pending_samples[0])
          report_mismatch("sample", out_sample, pending_samples[0]);
        void'(pending_samples.pop_front());
      end
    end
  end

  // offer one item, maybe after random gaps, and predict its sample once taken
  task automatic send_item(input logic adv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_advance <= adv;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (adv) acc_phase = acc_phase + freq_word;
    pending_samples.push_back(dds_sample(wave_sel, acc_phase));
  endtask

  // stop offering and let every pending sample come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the predictor follows what the block keeps of it
  task automatic write_reg(input dds_pkg::cfg_index_t idx,
                           input logic [dds_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == dds_pkg::REG_FREQUENCY_WORD) freq_word = data;
    else if (idx == dds_pkg::REG_WAVEFORM) wave_sel = data[dds_pkg::WAVE_BITS-1:0];
    @(posedge clk);
  endtask

  // reset registers: hold at phase zero, then a few steps of the default sine
  task automatic test_reset_values();
    send_item(1'b0);
    repeat (3) send_item(1'b1);
  endtask

  // register extremes, writes the block must ignore, and bits above the waveform width
  task automatic test_register_extremes();
    wait_idle();
    write_reg(dds_pkg::REG_FREQUENCY_WORD, '0);
    send_item(1'b1);
    send_item(1'b1);
    wait_idle();
    // all ones steps the phase back by one, wrapping below zero
    write_reg(dds_pkg::REG_FREQUENCY_WORD, '1);
    write_reg(dds_pkg::REG_WAVEFORM, dds_pkg::CFG_DATA_BITS'(dds_pkg::WAVE_RAMP));
    send_item(1'b1);
    send_item(1'b1);
    wait_idle();
    write_reg(REG_UNMAPPED, 32'h1234_5678);
    write_reg(REG_LAST_INDEX, '1);
    send_item(1'b1);
    wait_idle();
    write_reg(dds_pkg::REG_WAVEFORM,
              32'hFFFF_FFFC | dds_pkg::CFG_DATA_BITS'(dds_pkg::WAVE_SQUARE));
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // quarter turns from phase zero hit the half and quarter points of every table
  task automatic test_wave_shapes();
    dds_pkg::wave_t shapes[4];
    shapes = '{dds_pkg::WAVE_SQUARE, dds_pkg::WAVE_SINE, dds_pkg::WAVE_TRIANGLE,
               dds_pkg::WAVE_RAMP};
    wait_idle();
    write_reg(dds_pkg::REG_FREQUENCY_WORD, 32'd0 - acc_phase);
    send_item(1'b1);
    wait_idle();
    write_reg(dds_pkg::REG_FREQUENCY_WORD, 32'h4000_0000);
    foreach (shapes[s]) begin
      write_reg(dds_pkg::REG_WAVEFORM, dds_pkg::CFG_DATA_BITS'(shapes[s]));
      repeat (4) send_item(1'b1);
      wait_idle();
    end
  endtask

  // long hold-off on the result side while items keep coming, then a full drain
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(dds_pkg::REG_FREQUENCY_WORD, $urandom());
    write_reg(dds_pkg::REG_WAVEFORM, dds_pkg::CFG_DATA_BITS'(dds_pkg::WAVE_TRIANGLE));
    hold_request = HOLD_CYCLES;
    repeat (40) send_item($urandom_range(0, 1));
    wait_idle();
  endtask

  // random items in segments, each under a fresh register setting
  task automatic test_random(input int send_pct, input int recv_pct);
    logic [dds_pkg::CFG_DATA_BITS-1:0] freq_val;
    logic [dds_pkg::CFG_DATA_BITS-1:0] wave_val;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    repeat (4) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: freq_val = $urandom();
        // between 1 and 255 table points per step, plus fine bits
        1: freq_val = ($urandom_range(1, 255) << 24) | $urandom_range(0, 32'hFF_FFFF);
        2: freq_val = '0;
        3: freq_val = '1;
        4: freq_val = $urandom_range(1, 1 << 20);
        // exactly one table point per step: walks through every entry
        default: freq_val = 32'h0100_0000;
      endcase
      // waveform code in the low bits, random junk above
      wave_val = ($urandom() & ~32'h3) | $urandom_range(0, 3);
      if ($urandom_range(0, 1)) begin
        write_reg(dds_pkg::REG_FREQUENCY_WORD, freq_val);
        write_reg(dds_pkg::REG_WAVEFORM, wave_val);
      end else begin
        write_reg(dds_pkg::REG_WAVEFORM, wave_val);
        write_reg(dds_pkg::REG_FREQUENCY_WORD, freq_val);
      end
      repeat (SEGMENT_ITEMS) send_item($urandom_range(0, 9) < 7);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_wave_shapes();
    test_backpressure();
    test_random(15, 67);
    test_random(67, 15);
    test_random(0, 0);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
sv/dds_pkg.sv
sv/dds_wave_rom.sv
sv/dds_out_fifo.sv
sv/dds_waveform_generator.sv
verif/testbench.sv
